>>> src/tlss_pkg.sv
// Shared types, constants and helper functions for the track loss and
// static target supervisor. No dependencies.
package tlss_pkg;

    localparam int COUNT_WIDTH_DEF = 10;
    localparam int LIMIT_W         = 10;
    localparam int COORD_W         = 17;
    localparam int SIZE_W          = 16;
    localparam int SCORE_W         = 16;
    localparam int QUEUE_DEPTH     = 2;

    localparam int S_TDATA_W  = 88;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 24;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_FILT_EN = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_CTOL    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_STOL    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_SFL     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_RSL     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_ASL     = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_MLF     = 3'd6;

    localparam logic [SIZE_W-1:0]  CTOL_RST = 16'd32;
    localparam logic [SIZE_W-1:0]  STOL_RST = 16'd32;
    localparam logic [LIMIT_W-1:0] SFL_RST  = 10'd30;
    localparam logic [SCORE_W-1:0] RSL_RST  = 16'd19661;
    localparam logic [SCORE_W-1:0] ASL_RST  = 16'd32768;
    localparam logic [LIMIT_W-1:0] MLF_RST  = 10'd10;

    typedef enum logic [1:0] {
        REQ_TRACK = 2'd0,
        REQ_CAND  = 2'd1,
        REQ_DET   = 2'd2,
        REQ_NONE  = 2'd3
    } req_kind_t;

    typedef struct packed {
        logic                filt_en;
        logic [SIZE_W-1:0]   ctol;
        logic [SIZE_W-1:0]   stol;
        logic [LIMIT_W-1:0]  sfl;
        logic [SCORE_W-1:0]  rsl;
        logic [SCORE_W-1:0]  asl;
        logic [LIMIT_W-1:0]  mlf;
    } cfg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [SIZE_W-1:0]         w;
        logic [SIZE_W-1:0]         h;
    } box_t;

    typedef struct packed {
        req_kind_t kind;
        box_t      box;
        logic      box_ok;
        logic      score_low;
        logic      score_act;
    } item_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] loss_frames;
        logic               blocked_valid;
        logic               send_feedback;
        logic               blocked_match;
        logic               static_suspect;
        logic               is_tracked;
        logic               need_redetect;
        logic               tracking_active;
    } result_t;

    function automatic logic coord_near(logic signed [COORD_W-1:0] a,
                                        logic signed [COORD_W-1:0] b,
                                        logic [SIZE_W-1:0] tol);
        logic signed [COORD_W:0] d;
        logic [COORD_W:0]        m;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        m = d[COORD_W] ? (~d + 1'b1) : d;
        return m <= {{(COORD_W+1-SIZE_W){1'b0}}, tol};
    endfunction

    function automatic logic size_near(logic [SIZE_W-1:0] a, logic [SIZE_W-1:0] b,
                                       logic [SIZE_W-1:0] tol);
        logic [SIZE_W:0] d;
        logic [SIZE_W:0] m;
        d = {1'b0, a} - {1'b0, b};
        m = d[SIZE_W] ? (~d + 1'b1) : d;
        return m <= {1'b0, tol};
    endfunction

    function automatic logic box_near(box_t ref_box, box_t cur, logic [SIZE_W-1:0] ctol,
                                      logic [SIZE_W-1:0] stol);
        return coord_near(cur.cx, ref_box.cx, ctol) && coord_near(cur.cy, ref_box.cy, ctol)
            && size_near(cur.w, ref_box.w, stol) && size_near(cur.h, ref_box.h, stol);
    endfunction

endpackage

>>> src/tlss_front.sv
// Front end: unpacks the input transaction and classifies it.
// Depends on tlss_pkg.
module tlss_front
    import tlss_pkg::*;
(
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  cfg_t                 cfg,
    output item_t                item
);

    logic [SCORE_W-1:0] score;

    assign score = s_tdata[81:66];

    always_comb begin
        item.kind       = req_kind_t'(s_tuser);
        item.box.cx     = s_tdata[16:0];
        item.box.cy     = s_tdata[33:17];
        item.box.w      = s_tdata[49:34];
        item.box.h      = s_tdata[65:50];
        item.box_ok     = (s_tdata[49:34] != '0) && (s_tdata[65:50] != '0);
        item.score_low  = score < cfg.rsl;
        item.score_act  = score >= cfg.asl;
    end

endmodule

>>> src/tlss_queue.sv
// Short queue of classified items between front and back ends.
// Depends on tlss_pkg.
module tlss_queue
    import tlss_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  empty,
    output item_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               wr, rd;

    assign full     = cnt_reg == CNT_W'(DEPTH);
    assign empty    = cnt_reg == '0;
    assign wr       = push && !full;
    assign rd       = pop && !empty;
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr && !rd) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (rd && !wr) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> src/tlss_back.sv
// Back end: supervisor state update and the registered result stage.
// Depends on tlss_pkg.
module tlss_back
    import tlss_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 q_empty,
    input  item_t                q_item,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

    logic                   trk_reg, trk_next;
    logic [COUNT_WIDTH-1:0] loss_reg, loss_next;
    logic [COUNT_WIDTH-1:0] stab_reg, stab_next;
    logic                   lastv_reg, lastv_next;
    box_t                   last_reg, last_next;
    logic                   blkv_reg, blkv_next;
    box_t                   blk_reg, blk_next;
    logic                   reqs_reg, reqs_next;
    logic                   mvalid_reg, mvalid_next;
    result_t                res_reg, res_next;

    logic                   near_last, near_blk, st_run, suspect, drop_loss, need;
    logic [COUNT_WIDTH-1:0] stab_new, loss_new;
    logic [CMP_W-1:0]       loss_ext;

    assign q_pop    = !q_empty && (!mvalid_reg || m_tready);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - $bits(result_t)){1'b0}}, res_reg};

    assign near_last = box_near(last_reg, q_item.box, cfg.ctol, cfg.stol);
    assign near_blk  = box_near(blk_reg, q_item.box, cfg.ctol, cfg.stol);
    assign st_run    = cfg.filt_en && q_item.box_ok;

    always_comb begin
        if (near_last) begin
            stab_new = (stab_reg == '1) ? stab_reg : stab_reg + 1'b1;
        end else begin
            stab_new = '0;
        end
        if (q_item.score_low) begin
            loss_new = (loss_reg == '1) ? loss_reg : loss_reg + 1'b1;
        end else begin
            loss_new = '0;
        end
        suspect   = st_run && lastv_reg && (CMP_W'(stab_new) >= CMP_W'(cfg.sfl));
        drop_loss = CMP_W'(loss_new) >= CMP_W'(cfg.mlf);
        need      = drop_loss || suspect;
    end

    always_comb begin
        trk_next    = trk_reg;
        loss_next   = loss_reg;
        stab_next   = stab_reg;
        lastv_next  = lastv_reg;
        last_next   = last_reg;
        blkv_next   = blkv_reg;
        blk_next    = blk_reg;
        reqs_next   = reqs_reg;
        res_next    = '0;
        unique case (q_item.kind)
            REQ_TRACK: begin
                if (!trk_reg) begin
                    res_next.need_redetect = 1'b1;
                    if (!reqs_reg) begin
                        res_next.send_feedback = 1'b1;
                        reqs_next              = 1'b1;
                    end
                end else begin
                    reqs_next = 1'b0;
                    if (st_run) begin
                        last_next  = q_item.box;
                        lastv_next = 1'b1;
                        stab_next  = lastv_reg ? stab_new : '0;
                    end
                    loss_next = need ? '0 : loss_new;
                    trk_next  = !need;
                    if (suspect) begin
                        stab_next  = '0;
                        lastv_next = 1'b0;
                        blkv_next  = 1'b1;
                        blk_next   = q_item.box;
                    end
                    res_next.is_tracked      = !suspect;
                    res_next.static_suspect  = suspect;
                    res_next.need_redetect   = need;
                    res_next.send_feedback   = need;
                    res_next.tracking_active = !need && q_item.score_act;
                end
            end
            REQ_CAND: begin
                if (!trk_reg) begin
                    if (blkv_reg && near_blk) begin
                        res_next.blocked_match = 1'b1;
                    end else if (q_item.box_ok) begin
                        trk_next                 = 1'b1;
                        loss_next                = '0;
                        stab_next                = '0;
                        last_next                = q_item.box;
                        lastv_next               = 1'b1;
                        blkv_next                = 1'b0;
                        reqs_next                = 1'b0;
                        res_next.is_tracked      = 1'b1;
                        res_next.tracking_active = 1'b1;
                        res_next.send_feedback   = 1'b1;
                    end
                end
            end
            REQ_DET: begin
                if (trk_reg) begin
                    loss_next                = '0;
                    res_next.is_tracked      = 1'b1;
                    res_next.tracking_active = 1'b1;
                end
            end
            REQ_NONE: begin
            end
        endcase
        loss_ext               = CMP_W'(loss_next);
        res_next.blocked_valid = blkv_next;
        res_next.loss_frames   = loss_ext[LIMIT_W-1:0];
    end

    always_comb begin
        mvalid_next = mvalid_reg;
        if (q_pop) begin
            mvalid_next = 1'b1;
        end else if (m_tready) begin
            mvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trk_reg    <= 1'b0;
            loss_reg   <= '0;
            stab_reg   <= '0;
            lastv_reg  <= 1'b0;
            last_reg   <= '0;
            blkv_reg   <= 1'b0;
            blk_reg    <= '0;
            reqs_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            mvalid_reg <= mvalid_next;
            if (q_pop) begin
                trk_reg   <= trk_next;
                loss_reg  <= loss_next;
                stab_reg  <= stab_next;
                lastv_reg <= lastv_next;
                last_reg  <= last_next;
                blkv_reg  <= blkv_next;
                blk_reg   <= blk_next;
                reqs_reg  <= reqs_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            res_reg <= res_next;
        end
    end

endmodule

>>> src/track_loss_and_static_target_supervisor_unit.sv
// Top level of the track loss and static target supervisor: configuration
// registers, front end, item queue and back end. Depends on tlss_pkg,
// tlss_front, tlss_queue and tlss_back.
//
// Takes one tracker or detector frame transaction per clock while the result
// side does not stall, and returns one result transaction for each. The front
// end classifies the frame into a two-entry queue; the back end pops it,
// updates the track, loss, static and blocked box state and registers the
// result, so the sustained rate is one transaction per cycle while m_tready is
// high. s_tready drops only when the queue is full while the result side
// stalls. Write configuration only while no transaction is in flight.
module track_loss_and_static_target_supervisor_unit
    import tlss_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // box_cx[16:0], box_cy[33:17], box_w[49:34], box_h[65:50], score[81:66]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // req_type[1:0]
    input  logic [S_TUSER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // tracking_active[0], need_redetect[1], is_tracked[2], static_suspect[3],
    // blocked_match[4], send_feedback[5], blocked_valid[6], loss_frames[16:7]
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t  cfg_reg;
    item_t f_item;
    item_t q_item;
    logic  q_full, q_empty, q_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.filt_en <= 1'b0;
            cfg_reg.ctol    <= CTOL_RST;
            cfg_reg.stol    <= STOL_RST;
            cfg_reg.sfl     <= SFL_RST;
            cfg_reg.rsl     <= RSL_RST;
            cfg_reg.asl     <= ASL_RST;
            cfg_reg.mlf     <= MLF_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_IDX_FILT_EN: cfg_reg.filt_en <= cfg_wdata[0];
                CFG_IDX_CTOL:    cfg_reg.ctol    <= cfg_wdata;
                CFG_IDX_STOL:    cfg_reg.stol    <= cfg_wdata;
                CFG_IDX_SFL:     cfg_reg.sfl     <= cfg_wdata[LIMIT_W-1:0];
                CFG_IDX_RSL:     cfg_reg.rsl     <= cfg_wdata;
                CFG_IDX_ASL:     cfg_reg.asl     <= cfg_wdata;
                CFG_IDX_MLF:     cfg_reg.mlf     <= cfg_wdata[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_tready = !q_full;

    tlss_front u_front (
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .cfg     (cfg_reg),
        .item    (f_item)
    );

    tlss_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_tvalid),
        .push_item (f_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_item  (q_item)
    );

    tlss_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
